[hdl/complex_fir_filter_macros.svh]
`ifndef COMPLEX_FIR_FILTER_MACROS_SVH
`define COMPLEX_FIR_FILTER_MACROS_SVH

// same-cycle implication
`define CFIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cfir_pkg.sv]
package cfir_pkg;

  localparam int MAX_TAPS_DEF = 64;
  localparam int LANES        = 4;
  localparam int LANE_W       = $clog2(LANES);
  localparam int ACC_MAX_W    = 41;

  localparam logic [6:0]  TAP_COUNT_RST = 7'd64;
  localparam logic [15:0] SAT_POS       = 16'h7fff;
  localparam logic [15:0] SAT_NEG       = 16'h8000;

  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic clear;
    logic tap_we;
    logic hist_we;
    logic issue;
    logic en;
  } lane_ctl_t;

  function automatic logic [15:0] round_sat(input logic signed [ACC_MAX_W-1:0] a);
    logic             neg;
    logic [ACC_MAX_W:0] mag_in;
    logic [ACC_MAX_W:0] mag;
    logic [15:0]      r;
    neg    = a[ACC_MAX_W-1];
    mag_in = neg ? (~{a[ACC_MAX_W-1], a} + (ACC_MAX_W+1)'(1)) : {1'b0, a};
    mag    = (mag_in + (ACC_MAX_W+1)'(16384)) >> 15;
    if (!neg) begin
      r = (mag > (ACC_MAX_W+1)'(32767)) ? SAT_POS : mag[15:0];
    end else begin
      r = (mag > (ACC_MAX_W+1)'(32768)) ? SAT_NEG : (~mag[15:0] + 16'd1);
    end
    return r;
  endfunction

endpackage

[hdl/cfir_lane.sv]
module cfir_lane #(
  parameter int MAX_TAPS = cfir_pkg::MAX_TAPS_DEF,
  parameter int PTR_W    = 6,
  parameter int TB       = 16,
  parameter int TBW      = 4,
  parameter int ACC_W    = 39
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfir_pkg::lane_ctl_t      ctl,
  input  logic [TBW-1:0]           tap_waddr,
  input  logic signed [15:0]       tap_wdata,
  input  logic [TBW-1:0]           tap_raddr,
  input  logic [PTR_W-1:0]         hist_waddr,
  input  logic signed [15:0]       hist_wdata_i,
  input  logic signed [15:0]       hist_wdata_q,
  input  logic [PTR_W-1:0]         hist_raddr,
  output logic signed [ACC_W-1:0]  acc_i,
  output logic signed [ACC_W-1:0]  acc_q,
  output logic                     busy
);

  logic signed [15:0] tap_mem [TB];
  logic signed [15:0] hist_i  [MAX_TAPS];
  logic signed [15:0] hist_q  [MAX_TAPS];

  logic signed [15:0] tap_rd;
  logic signed [15:0] hi_rd;
  logic signed [15:0] hq_rd;
  logic signed [31:0] prod_i;
  logic signed [31:0] prod_q;
  logic               rd_v;
  logic               rd_en;
  logic               pr_v;

  always_ff @(posedge clk) begin
    if (ctl.tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    if (ctl.hist_we) begin
      hist_i[hist_waddr] <= hist_wdata_i;
      hist_q[hist_waddr] <= hist_wdata_q;
    end
    tap_rd <= tap_mem[tap_raddr];
    hi_rd  <= hist_i[hist_raddr];
    hq_rd  <= hist_q[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      rd_en <= 1'b0;
      pr_v  <= 1'b0;
    end else begin
      rd_v  <= ctl.issue;
      rd_en <= ctl.en;
      pr_v  <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      prod_i <= tap_rd * hi_rd;
      prod_q <= tap_rd * hq_rd;
    end else begin
      prod_i <= '0;
      prod_q <= '0;
    end
    if (ctl.clear) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (pr_v) begin
      acc_i <= acc_i + ACC_W'(prod_i);
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign busy = rd_v | pr_v;

endmodule

[hdl/cfir_merge.sv]
module cfir_merge #(
  parameter int ACC_W = 39
) (
  input  logic                    clk,
  input  logic                    sum_en,
  input  logic signed [ACC_W-1:0] acc_i [cfir_pkg::LANES],
  input  logic signed [ACC_W-1:0] acc_q [cfir_pkg::LANES],
  output logic [15:0]             res_i,
  output logic [15:0]             res_q
);

  logic signed [ACC_W-1:0] tot_i;
  logic signed [ACC_W-1:0] tot_q;
  logic signed [ACC_W-1:0] sum_i;
  logic signed [ACC_W-1:0] sum_q;

  always_comb begin
    tot_i = '0;
    tot_q = '0;
    for (int l = 0; l < cfir_pkg::LANES; l++) begin
      tot_i = tot_i + acc_i[l];
      tot_q = tot_q + acc_q[l];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_i <= tot_i;
      sum_q <= tot_q;
    end
  end

  assign res_i = cfir_pkg::round_sat(cfir_pkg::ACC_MAX_W'(sum_i));
  assign res_q = cfir_pkg::round_sat(cfir_pkg::ACC_MAX_W'(sum_q));

endmodule

[hdl/complex_fir_filter.sv]
// Complex FIR filter: one shared set of real Q1.15 taps applied to I and Q. A request with
// tuser 0 loads one coefficient (tap_index at or beyond MAX_TAPS is dropped) and leaves
// the block ready for the next request; a request with tuser 1 pushes an I/Q pair and
// yields one result, rounded half away from zero, shifted right 15 and saturated to int16.
// Four lanes each hold every fourth tap and a copy of the history, with one multiplier per
// channel and one read port per memory, so the lanes work through the first n taps four at
// a time, where n is tap_count clamped to 1..MAX_TAPS; then the lane pipelines drain and
// the merge sums the lanes. A new request is taken while the last result still waits on
// the output register. Taps and history read as zero after reset until written.
module complex_fir_filter #(
  parameter int MAX_TAPS = cfir_pkg::MAX_TAPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // tap_index, tap_value, sample_i, sample_q, zero pad
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_i, out_q
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data   // tap_count
);

  `include "complex_fir_filter_macros.svh"

  localparam int LANES  = cfir_pkg::LANES;
  localparam int LANE_W = cfir_pkg::LANE_W;
  localparam int PTR_W  = $clog2(MAX_TAPS);
  localparam int TB     = (MAX_TAPS + LANES - 1) / LANES;
  localparam int TBW    = (TB > 1) ? $clog2(TB) : 1;
  localparam int CMP_W  = ($clog2(MAX_TAPS + 2 * LANES) > 8) ?
                          $clog2(MAX_TAPS + 2 * LANES) : 8;
  localparam int ACC_W  = 32 + PTR_W + 1;
  localparam int STEP_D = LANES % MAX_TAPS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_ROUND = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [6:0]          tap_count;
  logic [PTR_W-1:0]    wp;
  logic [TBW-1:0]      step;
  logic [CMP_W-1:0]    n_reg;
  logic [CMP_W-1:0]    n_next;
  logic [CMP_W-1:0]    tc_ext;
  logic [CMP_W-1:0]    kbase;
  logic [MAX_TAPS-1:0] tap_valid;
  logic [MAX_TAPS-1:0] hist_valid;
  logic [PTR_W-1:0]    rp [LANES];
  logic                accept;
  logic                tap_load;
  logic                start;
  logic                last_step;
  logic                out_free;
  logic                sum_en;
  logic [LANES-1:0]    lane_busy;
  logic [CMP_W-1:0]    t_ext;
  logic                t_ok;

  logic [5:0]         in_tap_index;
  logic signed [15:0] in_tap_value;
  logic signed [15:0] in_sample_i;
  logic signed [15:0] in_sample_q;

  cfir_pkg::lane_ctl_t     ctl   [LANES];
  logic signed [ACC_W-1:0] acc_i [LANES];
  logic signed [ACC_W-1:0] acc_q [LANES];
  logic [15:0]             res_i;
  logic [15:0]             res_q;

  assign in_tap_index = s_tdata[5:0];
  assign in_tap_value = s_tdata[21:6];
  assign in_sample_i  = s_tdata[37:22];
  assign in_sample_q  = s_tdata[53:38];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign tap_load = accept && (s_tuser == cfir_pkg::REQ_TAP);
  assign start    = accept && (s_tuser == cfir_pkg::REQ_SAMPLE);

  assign t_ext = CMP_W'(in_tap_index);
  assign t_ok  = t_ext < CMP_W'(MAX_TAPS);

  assign tc_ext = CMP_W'(tap_count);
  assign n_next = (tap_count == 7'd0) ? CMP_W'(1) :
                  (tc_ext > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS) : tc_ext;

  assign kbase     = CMP_W'({step, {LANE_W{1'b0}}});
  assign last_step = (kbase + CMP_W'(LANES)) >= n_reg;
  assign out_free  = !m_tvalid || m_tready;
  assign sum_en    = (state == ST_DRAIN) && !(|lane_busy);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (last_step) state_next = ST_DRAIN;
      ST_DRAIN: if (sum_en) state_next = ST_ROUND;
      ST_ROUND: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tap_count  <= cfir_pkg::TAP_COUNT_RST;
      wp         <= '0;
      tap_valid  <= '0;
      hist_valid <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tap_count <= cfg_data;
      end
      if (tap_load && t_ok) begin
        tap_valid[t_ext[PTR_W-1:0]] <= 1'b1;
      end
      if (start) begin
        hist_valid[wp] <= 1'b1;
        wp <= (CMP_W'(wp) == CMP_W'(MAX_TAPS - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (state == ST_ROUND && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step  <= '0;
      n_reg <= n_next;
    end else if (state == ST_RUN) begin
      step <= step + TBW'(1);
    end
    if (state == ST_ROUND && out_free) begin
      m_tdata <= {res_q, res_i};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int LOFF = l % MAX_TAPS;
    logic [CMP_W-1:0] k;

    assign k = kbase + CMP_W'(l);

    always_ff @(posedge clk) begin
      if (start) begin
        rp[l] <= (CMP_W'(wp) >= CMP_W'(LOFF)) ? PTR_W'(CMP_W'(wp) - CMP_W'(LOFF)) :
                 PTR_W'(CMP_W'(wp) + CMP_W'(MAX_TAPS - LOFF));
      end else if (state == ST_RUN) begin
        rp[l] <= (CMP_W'(rp[l]) >= CMP_W'(STEP_D)) ? PTR_W'(CMP_W'(rp[l]) - CMP_W'(STEP_D)) :
                 PTR_W'(CMP_W'(rp[l]) + CMP_W'(MAX_TAPS - STEP_D));
      end
    end

    always_comb begin
      ctl[l].clear   = start;
      ctl[l].tap_we  = tap_load && t_ok && (t_ext[LANE_W-1:0] == LANE_W'(l));
      ctl[l].hist_we = start;
      ctl[l].issue   = (state == ST_RUN);
      ctl[l].en      = (state == ST_RUN) && (k < n_reg) &&
                       tap_valid[k[PTR_W-1:0]] && hist_valid[rp[l]];
    end

    cfir_lane #(
      .MAX_TAPS (MAX_TAPS),
      .PTR_W    (PTR_W),
      .TB       (TB),
      .TBW      (TBW),
      .ACC_W    (ACC_W)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl[l]),
      .tap_waddr    (TBW'(t_ext >> LANE_W)),
      .tap_wdata    (in_tap_value),
      .tap_raddr    (step),
      .hist_waddr   (wp),
      .hist_wdata_i (in_sample_i),
      .hist_wdata_q (in_sample_q),
      .hist_raddr   (rp[l]),
      .acc_i        (acc_i[l]),
      .acc_q        (acc_q[l]),
      .busy         (lane_busy[l])
    );
  end

  cfir_merge #(
    .ACC_W (ACC_W)
  ) u_merge (
    .clk    (clk),
    .sum_en (sum_en),
    .acc_i  (acc_i),
    .acc_q  (acc_q),
    .res_i  (res_i),
    .res_q  (res_q)
  );

  `CFIR_ASSERT_NEXT(a_sample_starts, start, state == ST_RUN, "sample request did not start")
  `CFIR_ASSERT_NOW(a_wp_range, 1'b1, CMP_W'(wp) < CMP_W'(MAX_TAPS), "write pointer out of range")
  `CFIR_ASSERT_NOW(a_run_in_range, state == ST_RUN, kbase < n_reg, "issue beyond tap count")
  `CFIR_ASSERT_NEXT(a_result_loads, state == ST_ROUND && out_free,
                    m_tvalid && state == ST_IDLE, "result not delivered")

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS        = cfir_pkg::MAX_TAPS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic               kind;
    logic [5:0]         idx;
    logic signed [15:0] coef;
    logic signed [15:0] si;
    logic signed [15:0] sq;
  } fir_req_t;

  typedef struct {
    logic [15:0] oi;
    logic [15:0] oq;
  } iq_out_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we   = 1'b0;
  logic [6:0]  cfg_data = '0;

  logic signed [15:0] coef_tab [TAPS];
  logic signed [15:0] hist_i [TAPS];
  logic signed [15:0] hist_q [TAPS];
  logic [5:0]         wr_ptr;
  logic [6:0]         tap_cnt_reg;

  fir_req_t pending_req[$];
  iq_out_t  expected_out[$];
  fir_req_t cur_req;

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int result_cnt   = 0;
  int error_cnt    = 0;
  int cycle_cnt    = 0;
  int idle_pct     = 15;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  complex_fir_filter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_cnt++;
  endtask

  // round half away from zero, drop 15 fraction bits, clip to int16
  function automatic logic [15:0] to_int16(longint acc);
    longint mag;
    if (acc >= 0) begin
      mag = (acc + 16384) >>> 15;
      return (mag > 32767) ? 16'h7fff : mag[15:0];
    end
    mag = (-acc + 16384) >>> 15;
    return (mag > 32768) ? 16'h8000 : 16'(-mag);
  endfunction

  function automatic void fir_predict(fir_req_t r);
    longint     acc_i;
    longint     acc_q;
    int         n;
    logic [5:0] pos;
    if (r.kind == cfir_pkg::REQ_TAP) begin
      coef_tab[r.idx] = r.coef;
      return;
    end
    hist_i[wr_ptr] = r.si;
    hist_q[wr_ptr] = r.sq;
    n = (tap_cnt_reg == 0) ? 1 : (tap_cnt_reg > TAPS) ? TAPS : int'(tap_cnt_reg);
    acc_i = 0;
    acc_q = 0;
    pos = wr_ptr;
    for (int k = 0; k < n; k++) begin
      acc_i += longint'(coef_tab[k]) * longint'(hist_i[pos]);
      acc_q += longint'(coef_tab[k]) * longint'(hist_q[pos]);
      pos = pos - 6'd1;
    end
    wr_ptr = wr_ptr + 6'd1;
    expected_out.push_back('{to_int16(acc_i), to_int16(acc_q)});
  endfunction

  function automatic logic signed [15:0] rand_coef(int amp);
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'(int'($urandom_range(0, 2 * amp)) - amp);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_tap(logic [5:0] idx, logic signed [15:0] c);
    fir_req_t r;
    r.kind = cfir_pkg::REQ_TAP;
    r.idx  = idx;
    r.coef = c;
    r.si   = 16'($urandom);
    r.sq   = 16'($urandom);
    pending_req.push_back(r);
    queued_cnt++;
  endfunction

  function automatic void push_sample(logic signed [15:0] si, logic signed [15:0] sq);
    fir_req_t r;
    r.kind = cfir_pkg::REQ_SAMPLE;
    r.idx  = 6'($urandom);
    r.coef = 16'($urandom);
    r.si   = si;
    r.sq   = sq;
    pending_req.push_back(r);
    queued_cnt++;
  endfunction

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_tap_count(logic [6:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tap_cnt_reg = v;
  endtask

  // preload the taps in use, then stream samples with stray tap writes mixed in
  task automatic run_phase(logic [6:0] count_reg, int n_items, int amp, bit quiet);
    int used;
    wait_idle();
    set_tap_count(count_reg);
    idle_pct = quiet ? 0 : 15;
    used = (count_reg == 0) ? 1 : (count_reg > TAPS) ? TAPS : int'(count_reg);
    for (int k = 0; k < used; k++) push_tap(6'(k), rand_coef(amp));
    for (int k = used; k < n_items; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_tap(6'($urandom), rand_coef(amp));
      end else begin
        push_sample(rand_sample(), rand_sample());
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        fir_predict(cur_req);
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_req.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_req = pending_req.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, cur_req.sq, cur_req.si, cur_req.coef, cur_req.idx};
          s_tuser  <= cur_req.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    iq_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          want = expected_out.pop_front();
          result_cnt++;
          if (m_tdata[15:0] !== want.oi) begin
            report_mismatch($sformatf("result %0d out_i got %h want %h",
                                      result_cnt, m_tdata[15:0], want.oi));
          end
          if (m_tdata[31:16] !== want.oq) begin
            report_mismatch($sformatf("result %0d out_q got %h want %h",
                                      result_cnt, m_tdata[31:16], want.oq));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && result_cnt >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < TAPS; k++) begin
      coef_tab[k] = '0;
      hist_i[k]   = '0;
      hist_q[k]   = '0;
    end
    wr_ptr      = '0;
    tap_cnt_reg = cfir_pkg::TAP_COUNT_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // full-scale taps at both ends of the table
    push_tap(6'd0, 16'sh7fff);
    push_tap(6'd63, 16'sh8000);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sh0000, 16'sh0001);
    wait_idle();

    // rounding ties and product overflow with a single tap
    set_tap_count(7'd1);
    push_tap(6'd0, 16'sh4000);
    push_sample(16'sh0001, 16'shffff);
    push_sample(16'sh0003, 16'shfffd);
    push_sample(16'sh7fff, 16'sh8000);
    push_tap(6'd0, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sh0001, 16'sh0000);

    run_phase(7'd127, 300, 512, 1'b0);
    run_phase(7'd0, 150, 32767, 1'b0);
    run_phase(7'd1, 150, 32767, 1'b0);
    run_phase(7'd64, 300, 32767, 1'b0);
    run_phase(7'd4, 200, 8192, 1'b1);
    run_phase(7'd13, 250, 4096, 1'b0);
    run_phase(7'd5, 200, 32767, 1'b0);
    run_phase(7'd33, 200, 1024, 1'b0);
    run_phase(7'd65, 150, 2048, 1'b0);
    wait_idle();

    $display("%0d requests accepted: %0d samples filtered and checked, %0d tap loads",
             accepted_cnt, result_cnt, accepted_cnt - result_cnt);
    $display("tap counts 0, 1, 4, 5, 13, 33, 64, 65, 127; one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (error_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/cfir_pkg.sv
hdl/cfir_lane.sv
hdl/cfir_merge.sv
hdl/complex_fir_filter.sv
tb/sv/tb.sv
